// File: rtl/core/base64url_decoder_core_assert.svh
// assertion macros used by the base64url decoder rtl
`ifndef BASE64URL_DECODER_CORE_ASSERT_SVH
`define BASE64URL_DECODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define B64D_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

// File: rtl/core/b64d_pkg.sv
// shared types, constants and symbol classifier of the base64url decoder
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // queue between classifier and decode engine
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // special characters
    localparam logic [7:0] SYM_DASH  = 8'h2D;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_UNDER = 8'h5F;
    localparam logic [7:0] SYM_SLASH = 8'h2F;
    localparam logic [7:0] SYM_PAD   = 8'h3D;
    localparam logic [7:0] SYM_NUL   = 8'h00;

    // closing status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_BAD   = 2'd2
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t  kind;
        logic [5:0] sextet;
        logic       last;
    } sym_item_t;

    // one queue port: valid flag with the classified character
    typedef struct packed {
        logic      valid;
        sym_item_t item;
    } q_slot_t;

    // map one character to its kind and 6-bit value
    function automatic sym_item_t classify(input logic [7:0] sym, input logic last);
        sym_item_t res;
        res.kind   = KIND_VALUE;
        res.sextet = 6'd0;
        res.last   = last;
        case (sym) inside
            [8'h41:8'h5A]: res.sextet = 6'(sym - 8'h41);
            [8'h61:8'h7A]: res.sextet = 6'(sym - 8'h61 + 8'd26);
            [8'h30:8'h39]: res.sextet = 6'(sym - 8'h30 + 8'd52);
            SYM_DASH, SYM_PLUS:   res.sextet = 6'd62;
            SYM_UNDER, SYM_SLASH: res.sextet = 6'd63;
            SYM_PAD, SYM_NUL:     res.kind = KIND_STOP;
            default:              res.kind = KIND_BAD;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/base64url_decoder_core.sv
// top level of the streaming base64url decoder
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  input   | in        | in_valid / in_ready  | symbol, last
//  result  | out       | out_valid / out_ready| data_byte, byte_valid, done_res, status, byte_count
//  config  | in        | cfg_we               | cfg_wdata (byte_capacity)
//
//  one character and one retired queue entry per cycle, unless a result waits on out_ready
//  a character enters the queue at its transfer and the result register when the back end pops it
//  a four-entry queue lets the input side keep transferring while a result waits on out_ready
//  reset clears all string state and sets byte_capacity to 65535; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module base64url_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  symbol,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic             byte_valid,
    output logic             done_res,
    output logic [1:0]       status,
    output logic [15:0]      byte_count
);
    import b64d_pkg::*;

    q_slot_t push;
    q_slot_t head;
    logic    q_full;
    logic    pop;

    // classify incoming characters
    b64d_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .symbol   (symbol),
        .last     (last),
        .q_full   (q_full),
        .push     (push)
    );

    // decouple the two sides
    b64d_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // decode and register results
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .done_res   (done_res),
        .status     (status),
        .byte_count (byte_count)
    );

endmodule

`default_nettype wire

// File: rtl/core/b64d_front.sv
// front end: accepts characters and classifies them into the queue
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        symbol,
    input  wire logic              last,
    input  wire logic              q_full,
    output b64d_pkg::q_slot_t      push
);
    import b64d_pkg::*;

    // take a character whenever the queue has room
    assign in_ready = !q_full;

    // classify and push on each transfer
    always_comb
    begin
        push.valid = in_valid && !q_full;
        push.item  = classify(symbol, last);
    end

endmodule

`default_nettype wire

// File: rtl/core/b64d_queue.sv
// short fifo of classified characters between front and back end
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b64d_pkg::q_slot_t  push,
    output logic                    full,
    output b64d_pkg::q_slot_t       head,
    input  wire logic               pop
);
    import b64d_pkg::*;

    sym_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_pop = pop && (count_reg != '0);

    // head entry
    always_comb
    begin
        head.valid = (count_reg != '0);
        head.item  = entry_reg[rd_ptr_reg];
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/b64d_back.sv
// back end: bit accumulator, byte count, status and result register
`timescale 1ns / 1ps
`default_nettype none
`include "base64url_decoder_core_assert.svh"

module b64d_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire b64d_pkg::q_slot_t  head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              data_byte,
    output logic                    byte_valid,
    output logic                    done_res,
    output logic [1:0]              status,
    output logic [15:0]             byte_count
);
    import b64d_pkg::*;

    logic [15:0] capacity_reg;
    logic [11:0] acc_reg;
    logic [11:0] acc_next;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic [1:0]  err_reg;
    logic [1:0]  err_next;

    logic        out_valid_reg;
    logic [7:0]  data_byte_reg;
    logic        byte_valid_reg;
    logic        done_res_reg;
    logic [1:0]  status_reg;
    logic [15:0] byte_count_reg;

    logic        take;
    logic        got_byte;
    logic [7:0]  byte_val;
    logic [11:0] acc_shift;
    logic [3:0]  pending_sum;
    logic [2:0]  pending_left;

    // consume the head when the result register is free or draining
    assign take = head.valid && (!out_valid_reg || out_ready);
    assign pop  = take;

    // decode one character
    always_comb
    begin
        acc_shift    = {acc_reg[5:0], head.item.sextet};
        pending_sum  = {1'b0, pending_reg} + 4'd6;
        pending_left = pending_sum[3] ? pending_sum[2:0] : pending_sum[2:0];
        acc_next     = acc_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        err_next     = err_reg;
        got_byte     = 1'b0;
        byte_val     = 8'd0;
        if (!stopped_reg && err_reg == STATUS_OK)
        begin
            case (head.item.kind)
                KIND_STOP:
                begin
                    stopped_next = 1'b1;
                end
                KIND_BAD:
                begin
                    err_next = STATUS_INVALID;
                end
                KIND_VALUE:
                begin
                    acc_next     = acc_shift;
                    pending_next = pending_left;
                    if (pending_sum[3])
                    begin
                        if (count_reg >= capacity_reg)
                        begin
                            err_next = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            got_byte   = 1'b1;
                            count_next = count_reg + 16'd1;
                            case (pending_left)
                                3'd2:    byte_val = acc_shift[9:2];
                                3'd4:    byte_val = acc_shift[11:4];
                                default: byte_val = acc_shift[7:0];
                            endcase
                        end
                    end
                end
                default:
                begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // per-string state, cleared after the closing character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pending_reg <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            err_reg     <= STATUS_OK;
        end
        else if (take)
        begin
            if (head.item.last)
            begin
                acc_reg     <= '0;
                pending_reg <= '0;
                count_reg   <= '0;
                stopped_reg <= 1'b0;
                err_reg     <= STATUS_OK;
            end
            else
            begin
                acc_reg     <= acc_next;
                pending_reg <= pending_next;
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
                err_reg     <= err_next;
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= got_byte || head.item.last;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_byte_reg  <= byte_val;
            byte_valid_reg <= got_byte;
            done_res_reg   <= head.item.last;
            status_reg     <= head.item.last ? err_next : STATUS_OK;
            byte_count_reg <= head.item.last ? count_next : 16'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign done_res   = done_res_reg;
    assign status     = status_reg;
    assign byte_count = byte_count_reg;

    // checks
    `B64D_ASSERT_IMPL(a_pending_even, 1'b1, pending_reg[0] == 1'b0)
    `B64D_ASSERT_IMPL(a_result_has_cause, out_valid_reg && !byte_valid_reg, done_res_reg)
    `B64D_ASSERT_IMPL(a_mid_string_quiet, out_valid_reg && !done_res_reg,
        status_reg == STATUS_OK && byte_count_reg == 16'd0)
    `B64D_ASSERT_NEXT(a_rearm_on_last, take && head.item.last,
        count_reg == 16'd0 && err_reg == STATUS_OK && !stopped_reg)
    `B64D_ASSERT_NEXT(a_halted_no_count,
        take && !head.item.last && (stopped_reg || err_reg != STATUS_OK),
        count_reg == $past(count_reg))

endmodule

`default_nettype wire
